[hdl/ptbt_pkg.sv]
`default_nettype none
package ptbt_pkg;

	localparam int CoordBits      = 24;
	localparam int WeightFracBits = 16;
	localparam int WeightBits     = WeightFracBits + 1;
	localparam int TolBits        = 16;
	localparam int DiffBits       = CoordBits + 1;
	localparam int CrossBits      = 2 * DiffBits + 1;
	localparam int LoBits         = (CrossBits + 1) / 2;
	localparam int MulABits       = LoBits + 1;
	localparam int MulBBits       = DiffBits;
	localparam int ProdBits       = MulABits + MulBBits;
	localparam int DotBits        = CrossBits + CoordBits + 2;
	localparam int RemBits        = DotBits + 1;
	localparam int SumBits        = WeightBits + 2;
	localparam int QDepth         = 2;
	localparam int PtrBits        = 1;
	localparam int StepBits       = 4;

	localparam logic [StepBits-1:0] StepDiff     = 4'd0;
	localparam logic [StepBits-1:0] StepDotFirst = 4'd7;
	localparam logic [StepBits-1:0] StepDotLast  = 4'd12;
	localparam logic [StepBits-1:0] StepStore    = 4'd14;
	localparam logic [1:0]          SlotLimit    = 2'd3;
	localparam logic [1:0]          PointSel     = 2'd3;
	localparam logic [1:0]          LastDot      = 2'd3;
	localparam logic [1:0]          LastWeight   = 2'd2;
	localparam logic [TolBits-1:0]  TolReset     = 16'd16;

	typedef enum logic [1:0] {
		CMD_VERTEX = 2'd0,
		CMD_NORMAL = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_VERTEX,
		OP_NORMAL,
		OP_QUERY
	} op_t;

	typedef struct packed {
		op_t                          op;
		logic [1:0]                   slot;
		logic signed [CoordBits-1:0]  x;
		logic signed [CoordBits-1:0]  y;
		logic signed [CoordBits-1:0]  z;
	} word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DOT,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_CROSS_ADD,
		ACC_CROSS_SUB,
		ACC_DOT_LO,
		ACC_DOT_HI
	} acc_t;

	typedef struct packed {
		logic               start;
		logic [DotBits-1:0] num;
		logic [DotBits-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [WeightBits-1:0] quo;
	} div_rsp_t;

endpackage
`default_nettype wire

[hdl/point_triangle_barycentric_test_core.sv]
// channel  direction  handshake             payload
// in       receive    in_valid / in_stall   cmd, vertex_slot, coord_x, coord_y, coord_z
// out      send       out_valid / out_stall inside_res, degenerate, weight_a..weight_c
// cfg      receive    cfg_we                cfg_wdata (sum_tolerance)
//
// a load writes its triangle corner or normal as it is popped; a query runs four dot
// products through one shared 27x25 multiplier, then three 17-step serial divisions,
// then the sum check; a degenerate triangle or an out-of-range weight ends it early.
// reset clears the triangle, normal and tolerance (16) at once; no clearing pass.
// a two-word queue lets the input take words while the back end works or the
// output register waits on out_stall.
`default_nettype none
module point_triangle_barycentric_test_core (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [1:0]                             cmd,
	input  wire logic [1:0]                             vertex_slot,
	input  wire logic signed [ptbt_pkg::CoordBits-1:0]  coord_x,
	input  wire logic signed [ptbt_pkg::CoordBits-1:0]  coord_y,
	input  wire logic signed [ptbt_pkg::CoordBits-1:0]  coord_z,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic                                        inside_res,
	output logic                                        degenerate,
	output logic [ptbt_pkg::WeightBits-1:0]             weight_a,
	output logic [ptbt_pkg::WeightBits-1:0]             weight_b,
	output logic [ptbt_pkg::WeightBits-1:0]             weight_c,
	input  wire logic                                   cfg_we,
	input  wire logic [ptbt_pkg::TolBits-1:0]           cfg_wdata
);

	logic [ptbt_pkg::TolBits-1:0] sum_tolerance_q;
	logic                         full;
	logic                         push;
	logic                         empty;
	logic                         pop;
	ptbt_pkg::word_t              push_word;
	ptbt_pkg::word_t              pop_word;
	ptbt_pkg::div_req_t           div_req;
	ptbt_pkg::div_rsp_t           div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_tolerance_q <= ptbt_pkg::TolReset;
		end else if (cfg_we) begin
			sum_tolerance_q <= cfg_wdata;
		end
	end

	ptbt_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.vertex_slot (vertex_slot),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.full        (full),
		.push        (push),
		.word        (push_word)
	);

	ptbt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_word),
		.full   (full),
		.pop    (pop),
		.rdata  (pop_word),
		.empty  (empty)
	);

	ptbt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ptbt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.word       (pop_word),
		.pop        (pop),
		.tol        (sum_tolerance_q),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.inside_res (inside_res),
		.degenerate (degenerate),
		.weight_a   (weight_a),
		.weight_b   (weight_b),
		.weight_c   (weight_c)
	);

endmodule
`default_nettype wire

[hdl/ptbt_front.sv]
`default_nettype none
module ptbt_front (
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [1:0]                            cmd,
	input  wire logic [1:0]                            vertex_slot,
	input  wire logic signed [ptbt_pkg::CoordBits-1:0] coord_x,
	input  wire logic signed [ptbt_pkg::CoordBits-1:0] coord_y,
	input  wire logic signed [ptbt_pkg::CoordBits-1:0] coord_z,
	input  wire logic                                  full,
	output logic                                       push,
	output ptbt_pkg::word_t                            word
);

	logic keep;

	always_comb begin
		keep = 1'b0;
		word.op = ptbt_pkg::OP_QUERY;
		word.slot = vertex_slot;
		word.x = coord_x;
		word.y = coord_y;
		word.z = coord_z;
		case (cmd)
			ptbt_pkg::CMD_VERTEX: begin
				word.op = ptbt_pkg::OP_VERTEX;
				keep = (vertex_slot != ptbt_pkg::SlotLimit);
			end
			ptbt_pkg::CMD_NORMAL: begin
				word.op = ptbt_pkg::OP_NORMAL;
				keep = 1'b1;
			end
			ptbt_pkg::CMD_QUERY: begin
				word.op = ptbt_pkg::OP_QUERY;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign in_stall = full;
	assign push = in_valid && !full && keep;

endmodule
`default_nettype wire

[hdl/ptbt_fifo.sv]
`default_nettype none
module ptbt_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ptbt_pkg::word_t wdata,
	output logic                 full,
	input  wire logic            pop,
	output ptbt_pkg::word_t      rdata,
	output logic                 empty
);

	ptbt_pkg::word_t mem_q [ptbt_pkg::QDepth];
	logic [ptbt_pkg::PtrBits-1:0] wr_ptr_q;
	logic [ptbt_pkg::PtrBits-1:0] rd_ptr_q;
	logic [ptbt_pkg::PtrBits:0]   cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == (ptbt_pkg::PtrBits+1)'(ptbt_pkg::QDepth));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

[hdl/ptbt_div.sv]
`default_nettype none
module ptbt_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ptbt_pkg::div_req_t req,
	output ptbt_pkg::div_rsp_t      rsp
);

	localparam int CntBits = $clog2(ptbt_pkg::WeightBits);

	logic                               busy_q;
	logic                               done_q;
	logic [CntBits-1:0]                 cnt_q;
	logic [ptbt_pkg::RemBits-1:0]       rem_q;
	logic [ptbt_pkg::DotBits-1:0]       den_q;
	logic [ptbt_pkg::WeightBits-1:0]    quo_q;
	logic [ptbt_pkg::RemBits-1:0]       trial;
	logic [ptbt_pkg::RemBits-1:0]       rem_next;
	logic                               ge;

	always_comb begin
		trial = (cnt_q == '0) ? rem_q : (rem_q << 1);
		ge = (trial >= ptbt_pkg::RemBits'(den_q));
		rem_next = ge ? (trial - ptbt_pkg::RemBits'(den_q)) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntBits'(ptbt_pkg::WeightBits - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= ptbt_pkg::RemBits'(req.num);
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[ptbt_pkg::WeightBits-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

endmodule
`default_nettype wire

[hdl/ptbt_back.sv]
`default_nettype none
module ptbt_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               empty,
	input  wire ptbt_pkg::word_t                    word,
	output logic                                    pop,
	input  wire logic [ptbt_pkg::TolBits-1:0]       tol,
	output ptbt_pkg::div_req_t                      div_req,
	input  wire ptbt_pkg::div_rsp_t                 div_rsp,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    inside_res,
	output logic                                    degenerate,
	output logic [ptbt_pkg::WeightBits-1:0]         weight_a,
	output logic [ptbt_pkg::WeightBits-1:0]         weight_b,
	output logic [ptbt_pkg::WeightBits-1:0]         weight_c
);

	localparam int CB = ptbt_pkg::CoordBits;
	localparam int DB = ptbt_pkg::DotBits;
	localparam int XB = ptbt_pkg::CrossBits;
	localparam int LB = ptbt_pkg::LoBits;
	localparam int WB = ptbt_pkg::WeightBits;
	localparam int SB = ptbt_pkg::SumBits;

	ptbt_pkg::state_t state_q, state_d;

	logic signed [CB-1:0]                  corner_q [9];
	logic signed [CB-1:0]                  normal_q [3];
	logic signed [CB-1:0]                  p_q [3];
	logic [ptbt_pkg::StepBits-1:0]         step_q;
	logic [1:0]                            dot_q;
	logic [1:0]                            wsel_q;
	logic signed [ptbt_pkg::DiffBits-1:0]  e_q [3];
	logic signed [ptbt_pkg::DiffBits-1:0]  f_q [3];
	logic signed [XB-1:0]                  cross_q [3];
	logic signed [DB-1:0]                  sum_q;
	logic [DB-1:0]                         d_q;
	logic                                  dneg_q;
	logic signed [DB-1:0]                  n_q [3];
	logic signed [ptbt_pkg::ProdBits-1:0]  prod_s1;
	ptbt_pkg::acc_t                        acc_s1;
	logic [1:0]                            comp_s1;
	logic [WB-1:0]                         w_q [3];
	logic                                  res_inside_q;
	logic                                  res_degen_q;
	logic                                  out_valid_q;
	logic                                  out_inside_q;
	logic                                  out_degen_q;
	logic [WB-1:0]                         out_w_q [3];

	logic [1:0]                            ia, ib, ic;
	logic signed [CB-1:0]                  va [3];
	logic signed [CB-1:0]                  vb [3];
	logic signed [CB-1:0]                  vc [3];
	logic signed [ptbt_pkg::MulABits-1:0]  mul_a;
	logic signed [ptbt_pkg::MulBBits-1:0]  mul_b;
	ptbt_pkg::acc_t                        acc_d;
	logic [1:0]                            comp_d;
	logic [ptbt_pkg::StepBits-1:0]         dstep;
	logic signed [DB-1:0]                  sum_neg;
	logic signed [DB-1:0]                  n_cur;
	logic                                  n_bad;
	logic [SB-1:0]                         wsum;
	logic signed [SB:0]                    dev;
	logic [SB:0]                           dev_mag;
	logic                                  sum_ok;
	logic                                  load_out;

	always_comb begin
		case (dot_q)
			2'd0: begin ia = 2'd0; ib = 2'd1; ic = 2'd2; end
			2'd1: begin ia = 2'd1; ib = 2'd2; ic = ptbt_pkg::PointSel; end
			2'd2: begin ia = 2'd2; ib = 2'd0; ic = ptbt_pkg::PointSel; end
			default: begin ia = 2'd0; ib = 2'd1; ic = ptbt_pkg::PointSel; end
		endcase
		for (int k = 0; k < 3; k++) begin
			va[k] = (ia == ptbt_pkg::PointSel) ? p_q[k] : corner_q[4'(ia) * 4'd3 + 4'(k)];
			vb[k] = (ib == ptbt_pkg::PointSel) ? p_q[k] : corner_q[4'(ib) * 4'd3 + 4'(k)];
			vc[k] = (ic == ptbt_pkg::PointSel) ? p_q[k] : corner_q[4'(ic) * 4'd3 + 4'(k)];
		end
	end

	// at most one multiply issued per step; its registered product is accumulated in the next cycle
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		acc_d = ptbt_pkg::ACC_NONE;
		comp_d = 2'd0;
		dstep = step_q - ptbt_pkg::StepDotFirst;
		if (state_q == ptbt_pkg::ST_DOT) begin
			case (step_q)
				4'd1: begin
					mul_a = ptbt_pkg::MulABits'(e_q[1]); mul_b = f_q[2];
					acc_d = ptbt_pkg::ACC_CROSS_ADD; comp_d = 2'd0;
				end
				4'd2: begin
					mul_a = ptbt_pkg::MulABits'(e_q[2]); mul_b = f_q[1];
					acc_d = ptbt_pkg::ACC_CROSS_SUB; comp_d = 2'd0;
				end
				4'd3: begin
					mul_a = ptbt_pkg::MulABits'(e_q[2]); mul_b = f_q[0];
					acc_d = ptbt_pkg::ACC_CROSS_ADD; comp_d = 2'd1;
				end
				4'd4: begin
					mul_a = ptbt_pkg::MulABits'(e_q[0]); mul_b = f_q[2];
					acc_d = ptbt_pkg::ACC_CROSS_SUB; comp_d = 2'd1;
				end
				4'd5: begin
					mul_a = ptbt_pkg::MulABits'(e_q[0]); mul_b = f_q[1];
					acc_d = ptbt_pkg::ACC_CROSS_ADD; comp_d = 2'd2;
				end
				4'd6: begin
					mul_a = ptbt_pkg::MulABits'(e_q[1]); mul_b = f_q[0];
					acc_d = ptbt_pkg::ACC_CROSS_SUB; comp_d = 2'd2;
				end
				default: begin
					if (step_q >= ptbt_pkg::StepDotFirst && step_q <= ptbt_pkg::StepDotLast) begin
						comp_d = dstep[2:1];
						mul_b = ptbt_pkg::MulBBits'(normal_q[dstep[2:1]]);
						if (dstep[0]) begin
							mul_a = ptbt_pkg::MulABits'(signed'(cross_q[dstep[2:1]][XB-1:LB]));
							acc_d = ptbt_pkg::ACC_DOT_HI;
						end else begin
							mul_a = ptbt_pkg::MulABits'({1'b0, cross_q[dstep[2:1]][LB-1:0]});
							acc_d = ptbt_pkg::ACC_DOT_LO;
						end
					end
				end
			endcase
		end
	end

	always_comb begin
		sum_neg = -sum_q;
		n_cur = n_q[wsel_q];
		n_bad = n_cur[DB-1] || (DB'(unsigned'(n_cur)) > d_q);
		wsum = SB'(w_q[0]) + SB'(w_q[1]) + SB'(w_q[2]);
		dev = signed'({1'b0, wsum}) - (SB+1)'(1 << ptbt_pkg::WeightFracBits);
		dev_mag = dev[SB] ? unsigned'(-dev) : unsigned'(dev);
		sum_ok = (dev_mag < (SB+1)'(tol));
		load_out = (state_q == ptbt_pkg::ST_OUT) && (!out_valid_q || !out_stall);
		div_req.start = (state_q == ptbt_pkg::ST_DIV_START) && !n_bad;
		div_req.num = unsigned'(n_cur);
		div_req.den = d_q;
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		case (state_q)
			ptbt_pkg::ST_IDLE: begin
				pop = !empty;
				if (!empty && word.op == ptbt_pkg::OP_QUERY) state_d = ptbt_pkg::ST_DOT;
			end
			ptbt_pkg::ST_DOT: begin
				if (step_q == ptbt_pkg::StepStore) begin
					if (dot_q == 2'd0 && sum_q == '0) state_d = ptbt_pkg::ST_OUT;
					else if (dot_q == ptbt_pkg::LastDot) state_d = ptbt_pkg::ST_DIV_START;
				end
			end
			ptbt_pkg::ST_DIV_START: begin
				state_d = n_bad ? ptbt_pkg::ST_OUT : ptbt_pkg::ST_DIV_WAIT;
			end
			ptbt_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = (wsel_q == ptbt_pkg::LastWeight) ? ptbt_pkg::ST_SUM
						: ptbt_pkg::ST_DIV_START;
				end
			end
			ptbt_pkg::ST_SUM: state_d = ptbt_pkg::ST_OUT;
			ptbt_pkg::ST_OUT: begin
				if (load_out) state_d = ptbt_pkg::ST_IDLE;
			end
			default: state_d = ptbt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptbt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			acc_s1 <= ptbt_pkg::ACC_NONE;
			for (int k = 0; k < 9; k++) corner_q[k] <= '0;
			for (int k = 0; k < 3; k++) normal_q[k] <= '0;
		end else begin
			state_q <= state_d;
			acc_s1 <= acc_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (pop) begin
				case (word.op)
					ptbt_pkg::OP_VERTEX: begin
						corner_q[4'(word.slot) * 4'd3]        <= word.x;
						corner_q[4'(word.slot) * 4'd3 + 4'd1] <= word.y;
						corner_q[4'(word.slot) * 4'd3 + 4'd2] <= word.z;
					end
					ptbt_pkg::OP_NORMAL: begin
						normal_q[0] <= word.x;
						normal_q[1] <= word.y;
						normal_q[2] <= word.z;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		comp_s1 <= comp_d;
		case (acc_s1)
			ptbt_pkg::ACC_CROSS_ADD: cross_q[comp_s1] <= cross_q[comp_s1] + XB'(prod_s1);
			ptbt_pkg::ACC_CROSS_SUB: cross_q[comp_s1] <= cross_q[comp_s1] - XB'(prod_s1);
			ptbt_pkg::ACC_DOT_LO:    sum_q <= sum_q + DB'(prod_s1);
			ptbt_pkg::ACC_DOT_HI:    sum_q <= sum_q + (DB'(prod_s1) <<< LB);
			default: ;
		endcase
		case (state_q)
			ptbt_pkg::ST_IDLE: begin
				if (pop && word.op == ptbt_pkg::OP_QUERY) begin
					p_q[0] <= word.x;
					p_q[1] <= word.y;
					p_q[2] <= word.z;
					dot_q <= 2'd0;
					step_q <= ptbt_pkg::StepDiff;
				end
			end
			ptbt_pkg::ST_DOT: begin
				if (step_q == ptbt_pkg::StepDiff) begin
					for (int k = 0; k < 3; k++) begin
						e_q[k] <= ptbt_pkg::DiffBits'(vb[k]) - ptbt_pkg::DiffBits'(va[k]);
						f_q[k] <= ptbt_pkg::DiffBits'(vc[k]) - ptbt_pkg::DiffBits'(va[k]);
						cross_q[k] <= '0;
					end
					sum_q <= '0;
				end
				if (step_q == ptbt_pkg::StepStore) begin
					step_q <= ptbt_pkg::StepDiff;
					dot_q <= dot_q + 1'b1;
					wsel_q <= 2'd0;
					if (dot_q == 2'd0) begin
						dneg_q <= sum_q[DB-1];
						d_q <= sum_q[DB-1] ? unsigned'(sum_neg) : unsigned'(sum_q);
						res_degen_q <= (sum_q == '0);
						res_inside_q <= 1'b0;
					end else begin
						n_q[dot_q - 2'd1] <= dneg_q ? sum_neg : sum_q;
					end
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			ptbt_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					w_q[wsel_q] <= div_rsp.quo;
					wsel_q <= wsel_q + 1'b1;
				end
			end
			ptbt_pkg::ST_SUM: res_inside_q <= sum_ok;
			default: ;
		endcase
		if (load_out) begin
			out_inside_q <= res_inside_q;
			out_degen_q <= res_degen_q;
			for (int k = 0; k < 3; k++) out_w_q[k] <= res_inside_q ? w_q[k] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign inside_res = out_inside_q;
	assign degenerate = out_degen_q;
	assign weight_a = out_w_q[0];
	assign weight_b = out_w_q[1];
	assign weight_c = out_w_q[2];

endmodule
`default_nettype wire
